// ===== design/rme_pkg.sv =====
`default_nettype none
package rme_pkg;

	localparam int SQRT_STEPS = 16;
	localparam int ONE_Q14 = 16384;

	typedef struct packed {
		logic signed [15:0] row1_col2;
		logic signed [15:0] row0_col2;
		logic signed [15:0] row2_col2;
		logic signed [15:0] row1_col0;
		logic signed [15:0] row1_col1;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        yaw_angle;
		logic signed [15:0] pitch_angle;
		logic [15:0]        roll_angle;
		logic               gimbal_lock;
	} out_item_t;

	// sideband through the cosine square root
	typedef struct packed {
		logic signed [15:0] s;
		logic               gimbal;
		logic               yaw_neg;
		logic               roll_neg;
		logic signed [15:0] r2c2;
		logic signed [15:0] r1c1;
	} tag_c_t;

	// sideband through the yaw square root
	typedef struct packed {
		logic [14:0]        c;
		logic signed [15:0] s;
		logic               gimbal;
		logic               yaw_neg;
		logic               roll_neg;
		logic signed [15:0] m_yaw;
	} tag_y_t;

	// atan(2^-k) in units of 2^-32 turn
	function automatic logic [31:0] atan_turn32(input int k);
		logic [31:0] t;
		case (k)
			0: t = 32'h20000000;
			1: t = 32'h12E4051E;
			2: t = 32'h09FB385B;
			3: t = 32'h051111D4;
			4: t = 32'h028B0D43;
			5: t = 32'h0145D7E1;
			6: t = 32'h00A2F61E;
			7: t = 32'h00517C55;
			8: t = 32'h0028BE53;
			9: t = 32'h00145F2F;
			10: t = 32'h000A2F98;
			11: t = 32'h000517CC;
			12: t = 32'h00028BE6;
			13: t = 32'h000145F3;
			14: t = 32'h0000A2FA;
			15: t = 32'h0000517D;
			16: t = 32'h000028BE;
			17: t = 32'h0000145F;
			18: t = 32'h00000A30;
			19: t = 32'h00000518;
			20: t = 32'h0000028C;
			21: t = 32'h00000146;
			22: t = 32'h000000A3;
			23: t = 32'h00000051;
			24: t = 32'h00000029;
			25: t = 32'h00000014;
			26: t = 32'h0000000A;
			27: t = 32'h00000005;
			28: t = 32'h00000003;
			29: t = 32'h00000001;
			30: t = 32'h00000001;
			default: t = 32'h00000000;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

// ===== design/rme_if.sv =====
`default_nettype none
interface rme_in_if;
	logic               valid;
	logic               ready;
	rme_pkg::in_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rme_out_if;
	logic               valid;
	logic               ready;
	rme_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/rotation_matrix_to_euler_angles_top.sv =====
`default_nettype none
// Y-X-Z Euler angle extractor. Takes five Q2.14 rotation matrix entries per
// transaction and returns yaw and roll in [0, 1) turn and signed pitch, all
// with 65536 = one turn, plus a gimbal lock flag (yaw and roll forced to 0).
// Fully pipelined: one transaction per clock while the output is not stalled
// (two 16-step square root
// pipelines, a CORDIC_STAGES-deep vectoring pipeline plus seven register
// stages, the first loaded at the accepting edge). A stall on the output
// holds the whole pipeline; ready is low only while the output register is
// full and not taken.
module rotation_matrix_to_euler_angles_top #(
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_STAGES = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	rme_in_if.sink   in_ch,
	rme_out_if.source out_ch
);
	localparam int TC_W = $bits(rme_pkg::tag_c_t);
	localparam int TY_W = $bits(rme_pkg::tag_y_t);

	logic en;
	logic out_vld_q;
	rme_pkg::out_item_t out_q;

	assign en = !out_vld_q || out_ch.ready;
	assign in_ch.ready = en;

	// stage 1: clamp sine
	logic               vld_s1;
	rme_pkg::tag_c_t    tag_s1;
	logic signed [15:0] s_in;

	always_comb begin
		if (in_ch.data.row1_col2 > 16'sd16384) begin
			s_in = 16'sd16384;
		end else if (in_ch.data.row1_col2 < -16'sd16384) begin
			s_in = -16'sd16384;
		end else begin
			s_in = in_ch.data.row1_col2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1.s <= s_in;
			tag_s1.gimbal <= (s_in == 16'sd16384) || (s_in == -16'sd16384);
			tag_s1.yaw_neg <= in_ch.data.row0_col2 > 16'sd0;
			tag_s1.roll_neg <= in_ch.data.row1_col0 > 16'sd0;
			tag_s1.r2c2 <= in_ch.data.row2_col2;
			tag_s1.r1c1 <= in_ch.data.row1_col1;
		end
	end

	// stage 2: 1 - s^2
	logic               vld_s2;
	rme_pkg::tag_c_t    tag_s2;
	logic [28:0]        rad_s2;
	logic signed [31:0] s_sq;
	logic signed [31:0] rad_full;
	assign s_sq = tag_s1.s * tag_s1.s;
	assign rad_full = 32'sd268435456 - s_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s2 <= tag_s1;
			rad_s2 <= rad_full[28:0];
		end
	end

	// cosine of pitch
	logic            vld_c;
	logic [14:0]     c_root;
	logic [TC_W-1:0] tag_c_raw;
	rme_pkg::tag_c_t tag_c;

	rme_isqrt #(.TAG_W(TC_W)) u_sqrt_c (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld_s2), .rad_in(rad_s2), .tag_in(tag_s2),
		.vld_out(vld_c), .root_out(c_root), .tag_out(tag_c_raw)
	);
	assign tag_c = tag_c_raw;

	// stage 3: clamp cosine numerators to +-c
	logic signed [16:0] c_sx;
	logic signed [16:0] y_raw, r_raw;
	logic signed [15:0] m_yaw_nx, m_roll_nx;
	assign c_sx = {2'b00, c_root};
	assign y_raw = 17'(tag_c.r2c2);
	assign r_raw = 17'(tag_c.r1c1);

	always_comb begin
		if (y_raw > c_sx) begin
			m_yaw_nx = c_sx[15:0];
		end else if (y_raw < -c_sx) begin
			m_yaw_nx = 16'(-c_sx);
		end else begin
			m_yaw_nx = y_raw[15:0];
		end
		if (r_raw > c_sx) begin
			m_roll_nx = c_sx[15:0];
		end else if (r_raw < -c_sx) begin
			m_roll_nx = 16'(-c_sx);
		end else begin
			m_roll_nx = r_raw[15:0];
		end
	end

	logic               vld_s3;
	rme_pkg::tag_y_t    tag_s3;
	logic signed [15:0] m_roll_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s3.c <= c_root;
			tag_s3.s <= tag_c.s;
			tag_s3.gimbal <= tag_c.gimbal;
			tag_s3.yaw_neg <= tag_c.yaw_neg;
			tag_s3.roll_neg <= tag_c.roll_neg;
			tag_s3.m_yaw <= m_yaw_nx;
			m_roll_s3 <= m_roll_nx;
		end
	end

	// stage 4: c^2 - m^2
	logic signed [31:0] c_sq, my_sq, mr_sq, dy_full, dr_full;
	assign c_sq = $signed({17'd0, tag_s3.c}) * $signed({17'd0, tag_s3.c});
	assign my_sq = tag_s3.m_yaw * tag_s3.m_yaw;
	assign mr_sq = m_roll_s3 * m_roll_s3;
	assign dy_full = c_sq - my_sq;
	assign dr_full = c_sq - mr_sq;

	logic               vld_s4;
	rme_pkg::tag_y_t    tag_s4;
	logic signed [15:0] m_roll_s4;
	logic [28:0]        dy_s4, dr_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s4 <= tag_s3;
			m_roll_s4 <= m_roll_s3;
			dy_s4 <= dy_full[28:0];
			dr_s4 <= dr_full[28:0];
		end
	end

	// sine magnitudes of yaw and roll
	logic            vld_ny, vld_nr;
	logic [14:0]     n_yaw, n_roll;
	logic [TY_W-1:0] tag_ny_raw;
	logic [15:0]     m_roll_n;
	rme_pkg::tag_y_t tag_ny;

	rme_isqrt #(.TAG_W(TY_W)) u_sqrt_yaw (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld_s4), .rad_in(dy_s4), .tag_in(tag_s4),
		.vld_out(vld_ny), .root_out(n_yaw), .tag_out(tag_ny_raw)
	);

	rme_isqrt #(.TAG_W(16)) u_sqrt_roll (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld_s4), .rad_in(dr_s4), .tag_in(m_roll_s4),
		.vld_out(vld_nr), .root_out(n_roll), .tag_out(m_roll_n)
	);
	assign tag_ny = tag_ny_raw;

	// three angle pipelines in lockstep
	logic        vld_p, vld_y, vld_r;
	logic [15:0] ang_p, ang_y, ang_r;
	logic [1:0]  tag_p;
	logic        tag_y, tag_r;

	rme_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES), .TAG_W(2)) u_pitch (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_ny),
		.x_in({1'b0, tag_ny.c}), .y_in(tag_ny.s),
		.tag_in({tag_ny.gimbal, tag_ny.s[15]}),
		.vld_out(vld_p), .ang_out(ang_p), .tag_out(tag_p)
	);

	rme_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES), .TAG_W(1)) u_yaw (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_ny),
		.x_in(tag_ny.m_yaw), .y_in({1'b0, n_yaw}), .tag_in(tag_ny.yaw_neg),
		.vld_out(vld_y), .ang_out(ang_y), .tag_out(tag_y)
	);

	rme_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES), .TAG_W(1)) u_roll (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_ny),
		.x_in($signed(m_roll_n)), .y_in({1'b0, n_roll}), .tag_in(tag_ny.roll_neg),
		.vld_out(vld_r), .ang_out(ang_r), .tag_out(tag_r)
	);

	// output register: mirror and gimbal lock override
	logic gimbal_p;
	assign gimbal_p = tag_p[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_p;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.gimbal_lock <= gimbal_p;
			if (gimbal_p) begin
				out_q.yaw_angle <= '0;
				out_q.roll_angle <= '0;
				out_q.pitch_angle <= tag_p[0] ? -16'sd16384 : 16'sd16384;
			end else begin
				out_q.yaw_angle <= tag_y ? 16'(-ang_y) : ang_y;
				out_q.roll_angle <= tag_r ? 16'(-ang_r) : ang_r;
				out_q.pitch_angle <= $signed(ang_p);
			end
		end
	end

	assign out_ch.valid = out_vld_q;
	assign out_ch.data = out_q;

	a_cordic_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_p == vld_y) && (vld_p == vld_r))
		else $error("angle pipelines out of step");

	a_sqrt_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		vld_ny == vld_nr)
		else $error("square root pipelines out of step");

	a_gimbal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.gimbal_lock |->
		(out_ch.data.yaw_angle == 16'd0) && (out_ch.data.roll_angle == 16'd0) &&
		((out_ch.data.pitch_angle == 16'sd16384) || (out_ch.data.pitch_angle == -16'sd16384)))
		else $error("gimbal lock output not forced");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(out_q) && $stable(vld_ny))
		else $error("pipeline moved during stall");
endmodule
`default_nettype wire

// ===== design/rme_isqrt.sv =====
`default_nettype none
// Pipelined integer square root, one result bit per stage.
module rme_isqrt #(
	parameter int TAG_W = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             vld_in,
	input  wire logic [28:0]      rad_in,
	input  wire logic [TAG_W-1:0] tag_in,
	output logic                  vld_out,
	output logic [14:0]           root_out,
	output logic [TAG_W-1:0]      tag_out
);
	localparam int N = rme_pkg::SQRT_STEPS;

	logic [31:0]      v_s [0:N];
	logic [31:0]      r_s [0:N];
	logic             vld_s [0:N];
	logic [TAG_W-1:0] tag_s [0:N];

	always_comb begin
		v_s[0] = {3'b000, rad_in};
		r_s[0] = '0;
		vld_s[0] = vld_in;
		tag_s[0] = tag_in;
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [31:0] BIT = 32'(1) << (2 * (N - 1 - k));
		logic [31:0] trial;
		logic        take;
		assign trial = r_s[k] + BIT;
		assign take = v_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				v_s[k+1] <= take ? v_s[k] - trial : v_s[k];
				r_s[k+1] <= take ? (r_s[k] >> 1) + BIT : r_s[k] >> 1;
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign vld_out = vld_s[N];
	assign root_out = r_s[N][14:0];
	assign tag_out = tag_s[N];
endmodule
`default_nettype wire

// ===== design/rme_cordic.sv =====
`default_nettype none
// Pipelined CORDIC vectoring: angle of (x, y) as a fraction of a turn, 16-bit out.
module rme_cordic #(
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_STAGES = 16,
	parameter int TAG_W = 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               vld_in,
	input  wire logic signed [15:0] x_in,
	input  wire logic signed [15:0] y_in,
	input  wire logic [TAG_W-1:0]   tag_in,
	output logic                    vld_out,
	output logic [15:0]             ang_out,
	output logic [TAG_W-1:0]        tag_out
);
	localparam int N = CORDIC_STAGES;
	localparam int AB = ANGLE_BITS;
	localparam int SH = 32 - AB;
	localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

	logic signed [33:0] x_s [0:N];
	logic signed [33:0] y_s [0:N];
	logic [AB-1:0]      z_s [0:N];
	logic               vld_s [0:N];
	logic [TAG_W-1:0]   tag_s [0:N];

	logic signed [33:0] xw, yw;
	assign xw = 34'(x_in) <<< 16;
	assign yw = 34'(y_in) <<< 16;

	// quarter-turn pre-rotation into the right half plane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= tag_in;
			if (xw < 0) begin
				if (yw >= 0) begin
					x_s[0] <= yw;
					y_s[0] <= -xw;
					z_s[0] <= QUARTER;
				end else begin
					x_s[0] <= -yw;
					y_s[0] <= xw;
					z_s[0] <= -QUARTER;
				end
			end else begin
				x_s[0] <= xw;
				y_s[0] <= yw;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam logic [32:0] T = {1'b0, rme_pkg::atan_turn32(i)} + ((33'd1 << SH) >> 1);
		localparam logic [AB-1:0] ANG = T[SH +: AB];
		logic signed [33:0] dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[i+1] <= tag_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + ANG;
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - ANG;
				end
			end
		end
	end

	logic [15:0] rnd;
	if (AB > 16) begin : g_rnd
		localparam logic [AB-1:0] HALF = AB'(1) << (AB - 17);
		logic [AB-1:0] sum;
		assign sum = z_s[N] + HALF;
		assign rnd = sum[AB-1 -: 16];
	end else if (AB == 16) begin : g_eq
		assign rnd = z_s[N];
	end else begin : g_pad
		assign rnd = {z_s[N], {(16 - AB){1'b0}}};
	end

	logic        vld_q;
	logic [15:0] ang_q;
	logic [TAG_W-1:0] tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_q <= rnd;
			tag_q <= tag_s[N];
		end
	end

	assign vld_out = vld_q;
	assign ang_out = ang_q;
	assign tag_out = tag_q;
endmodule
`default_nettype wire

// ===== tb/rme_scoreboard.sv =====
`timescale 1ns / 100ps
class rme_scoreboard;
	rme_pkg::out_item_t angles_q[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	static function longint floor_shr(longint v, int k);
		return v >>> k;
	endfunction

	static function longint isqrt(longint v);
		longint r, b;
		r = 0;
		b = 64'd1 << 30;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// atan2 by vectoring, result in 2^-16 turn
	static function logic [15:0] vector_angle(longint x, longint y);
		logic [31:0] acc;
		logic [31:0] step;
		longint t, dx, dy;
		acc = '0;
		x = x * 65536;
		y = y * 65536;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				acc = 32'h4000;
			end else begin
				x = -y;
				y = t;
				acc = -32'sh4000;
			end
		end
		for (int i = 0; i < 16; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			step = (rme_pkg::atan_turn32(i) + 32'h8000) >> 16;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				acc = acc + step;
			end else begin
				x = x - dx;
				y = y + dy;
				acc = acc - step;
			end
		end
		return acc[15:0];
	endfunction

	static function logic [15:0] folded(logic signed [15:0] cr, logic signed [15:0] sr,
			longint c);
		longint m, n;
		logic [15:0] a;
		m = cr;
		if (m < -c) m = -c;
		if (m > c) m = c;
		n = isqrt(c * c - m * m);
		a = vector_angle(m, n);
		if (sr > 0) a = -a;
		return a;
	endfunction

	function void note_matrix(rme_pkg::in_item_t m);
		rme_pkg::out_item_t r;
		longint s, c;
		s = m.row1_col2;
		if (s > 16384) s = 16384;
		if (s < -16384) s = -16384;
		if (s == 16384 || s == -16384) begin
			r.yaw_angle = '0;
			r.roll_angle = '0;
			r.pitch_angle = (s > 0) ? 16'sh4000 : -16'sh4000;
			r.gimbal_lock = 1'b1;
		end else begin
			c = isqrt(268435456 - s * s);
			r.yaw_angle = folded(m.row2_col2, m.row0_col2, c);
			r.pitch_angle = vector_angle(c, s);
			r.roll_angle = folded(m.row1_col1, m.row1_col0, c);
			r.gimbal_lock = 1'b0;
		end
		angles_q.push_back(r);
	endfunction

	function void check_angles(rme_pkg::out_item_t got);
		rme_pkg::out_item_t e;
		if (angles_q.size() == 0) begin
			$display("%0t: unexpected transaction %h", $time, got);
			errors++;
			return;
		end
		e = angles_q.pop_front();
		if (got.yaw_angle !== e.yaw_angle) begin
			$display("%0t: yaw exp %h got %h", $time, e.yaw_angle, got.yaw_angle);
			errors++;
		end
		if (got.pitch_angle !== e.pitch_angle) begin
			$display("%0t: pitch exp %h got %h", $time, e.pitch_angle, got.pitch_angle);
			errors++;
		end
		if (got.roll_angle !== e.roll_angle) begin
			$display("%0t: roll exp %h got %h", $time, e.roll_angle, got.roll_angle);
			errors++;
		end
		if (got.gimbal_lock !== e.gimbal_lock) begin
			$display("%0t: gimbal exp %b got %b", $time, e.gimbal_lock, got.gimbal_lock);
			errors++;
		end
	endfunction
endclass

// ===== tb/rotation_matrix_to_euler_angles_top_test.sv =====
`timescale 1ns / 100ps
module rotation_matrix_to_euler_angles_top_test;

	logic clk;
	logic arst_n;
	rme_in_if in_ch ();
	rme_out_if out_ch ();

	rotation_matrix_to_euler_angles_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	rme_scoreboard board;
	rme_pkg::in_item_t matrices[$];
	bit hold_off;
	longint cycles;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic logic signed [15:0] pick_entry();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return 16'sh4000;
			4: return -16'sh4000;
			5: return 16'($urandom_range(0, 32) - 16);
			default: return 16'($urandom_range(0, 32768) - 16384);
		endcase
	endfunction

	// mostly in-range entries mixed with edge values, some raw noise
	function automatic rme_pkg::in_item_t random_matrix();
		rme_pkg::in_item_t m;
		m.row1_col2 = 16'($urandom);
		m.row0_col2 = 16'($urandom);
		m.row2_col2 = 16'($urandom);
		m.row1_col0 = 16'($urandom);
		m.row1_col1 = 16'($urandom);
		if ($urandom_range(0, 3) != 0) begin
			m.row1_col2 = $urandom_range(0, 20) == 0 ? pick_entry() :
				16'($urandom_range(0, 32766) - 16383);
			m.row0_col2 = pick_entry();
			m.row2_col2 = pick_entry();
			m.row1_col0 = pick_entry();
			m.row1_col1 = pick_entry();
		end
		return m;
	endfunction

	task automatic send_matrix(rme_pkg::in_item_t m);
		in_ch.valid <= 1'b1;
		in_ch.data <= m;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		board.note_matrix(m);
		@(negedge clk);
	endtask

	task automatic run_sender();
		int burst;
		while (matrices.size() > 0) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && matrices.size() > 0) begin
				send_matrix(matrices.pop_front());
				burst--;
			end
			if ($urandom_range(0, 2) != 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		in_ch.valid <= 1'b0;
	endtask

	// receiver stall pattern
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off)
				out_ch.ready <= 1'b0;
			else if (cycles % 700 < 200)
				out_ch.ready <= 1'b1;
			else
				out_ch.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk)
		if (arst_n && out_ch.valid && out_ch.ready)
			board.check_angles(out_ch.data);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		rme_pkg::in_item_t m;
		logic signed [15:0] edge_vals[6];
		board = new();
		cycles = 0;
		hold_off = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		edge_vals = '{16'sh8000, 16'sh7FFF, 16'sh4000, -16'sh4000, 16'sh0000, 16'sh0001};
		foreach (edge_vals[i]) begin
			m = '{edge_vals[i], edge_vals[5 - i], edge_vals[i], edge_vals[(i + 2) % 6],
				edge_vals[(i + 3) % 6]};
			matrices.push_back(m);
		end
		matrices.push_back('{16'sh2000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000});
		matrices.push_back('{16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh0000, 16'sh8000});
		matrices.push_back('{16'sh0000, 16'sh0100, -16'sh0100, -16'sh0100, 16'sh0100});
		matrices.push_back('{-16'sh3FFF, 16'sh0010, 16'sh0005, 16'sh7FFF, -16'sh7FFF});
		matrices.push_back('{16'sh3FFF, -16'sh0001, 16'sh0000, 16'sh0001, 16'sh0000});
		matrices.push_back('{16'sh4001, 16'sh1234, 16'sh1234, 16'sh1234, 16'sh1234});
		matrices.push_back('{16'sh0B50, -16'sh2D41, 16'sh2D41, 16'sh2D41, 16'sh2D41});
		for (int i = 0; i < 1300; i++) matrices.push_back(random_matrix());
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		fork
			run_sender();
			begin
				repeat (300) @(negedge clk);
				hold_off = 1'b1;
				repeat (200) @(negedge clk);
				hold_off = 1'b0;
			end
		join
		while (board.angles_q.size() > 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (board.errors == 0 && board.angles_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// ===== filelist.f =====
design/rme_pkg.sv
design/rme_if.sv
design/rme_isqrt.sv
design/rme_cordic.sv
design/rotation_matrix_to_euler_angles_top.sv
tb/rme_scoreboard.sv
tb/rotation_matrix_to_euler_angles_top_test.sv
